FILE: rtl/core/kbucket_peer_status_update_macros.svh
// assertion helpers used by kbps_datapath
`ifndef KBUCKET_PEER_STATUS_UPDATE_MACROS_SVH
`define KBUCKET_PEER_STATUS_UPDATE_MACROS_SVH

// same-cycle implication
`define KBPS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define KBPS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/kbps_pkg.sv
package kbps_pkg;

    localparam int NUM_BUCKETS     = 128;
    localparam int BKT_W           = 7;
    localparam int CHUNK_W         = 16;
    localparam int NUM_CHUNKS      = 8;
    localparam int CHUNK_IDX_W     = 3;
    localparam int DEF_BUCKET_SIZE = 8;
    localparam int HASH_W          = 64;
    localparam int IP_W            = 32;
    localparam int PORT_W          = 16;
    localparam int MISS_W          = 8;
    localparam int CAP_W           = 4;
    localparam int STATUS_W        = 3;
    localparam int FILL_W          = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int IN_DATA_W       = 2 * HASH_W + IP_W + PORT_W;
    localparam int IN_USER_W       = 2;
    localparam int OUT_DATA_W      = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_IGNORED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_EVICTED   = 3'd2,
        ST_REFRESHED = 3'd3,
        ST_MISS      = 3'd4,
        ST_REMOVED   = 3'd5,
        ST_ABSENT    = 3'd6
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCAL_HASH_HIGH = 3'd0,
        CFG_LOCAL_HASH_LOW  = 3'd1,
        CFG_LOCAL_IP        = 3'd2,
        CFG_LOCAL_PORT      = 3'd3,
        CFG_EXTERNAL_IP     = 3'd4,
        CFG_MISS_THRESHOLD  = 3'd5,
        CFG_BUCKET_CAPACITY = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FIND,
        S_META,
        S_SCAN,
        S_UPDATE,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic check;
        logic find_step;
        logic meta_rd;
        logic scan_step;
        logic update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic ignore;
        logic chunk_hit;
        logic scan_last;
        logic out_free;
    } sts_t;

    function automatic logic [3:0] top16(input logic [CHUNK_W-1:0] x);
        logic [3:0] p;
        p = '0;
        for (int i = 0; i < CHUNK_W; i++)
        begin
            if (x[i])
            begin
                p = 4'(i);
            end
        end
        return p;
    endfunction

endpackage

FILE: rtl/core/kbucket_peer_status_update.sv
// flow: an ignored item goes from the check straight to its result; any other item runs
// the bucket search over up to 8 16-bit chunks, a metadata read, an entry scan of all
// BUCKET_SIZE entries through the single read port of the entry store, and an update
// throughput: one item at a time, next item taken the cycle after its result registers
// reset: all stores read as empty at once through per-bucket row valid flops, no clearing pass
// configuration registers return to their listed reset values
module kbucket_peer_status_update
    import kbps_pkg::*;
#(
    parameter int BUCKET_SIZE = DEF_BUCKET_SIZE
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // peer_hash_high, peer_hash_low, peer_ip, peer_port
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // is_alive, is_nonroutable
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status, bucket_index, bucket_fill, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    cmd_t cmd;
    sts_t sts;

    kbps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kbps_datapath #(
        .BUCKET_SIZE (BUCKET_SIZE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: rtl/core/kbps_ctrl.sv
module kbps_ctrl
    import kbps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.ignore ? S_RESULT : S_FIND;
            end
            S_FIND:
            begin
                cmd.find_step = 1'b1;
                if (sts.chunk_hit)
                begin
                    state_next = S_META;
                end
            end
            S_META:
            begin
                cmd.meta_rd = 1'b1;
                state_next  = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/kbps_datapath.sv
`include "kbucket_peer_status_update_macros.svh"

module kbps_datapath
    import kbps_pkg::*;
#(
    parameter int BUCKET_SIZE = DEF_BUCKET_SIZE
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  cmd_t                  cmd,
    output sts_t                  sts
);

    localparam int IW    = (BUCKET_SIZE > 1) ? $clog2(BUCKET_SIZE) : 1;
    localparam int RW    = IW;
    localparam int CW    = $clog2(BUCKET_SIZE + 1);
    localparam int SLOTS = NUM_BUCKETS * BUCKET_SIZE;
    localparam int AW    = $clog2(SLOTS);
    localparam int MW    = BUCKET_SIZE * (1 + RW) + CW;
    localparam int EW    = 2 * HASH_W + IP_W + PORT_W + MISS_W;
    localparam int KW    = ((CW > CAP_W) ? CW : CAP_W) + 1;

    // configuration
    logic [HASH_W-1:0] local_hash_high_reg;
    logic [HASH_W-1:0] local_hash_low_reg;
    logic [IP_W-1:0]   local_ip_reg;
    logic [PORT_W-1:0] local_port_reg;
    logic [IP_W-1:0]   external_ip_reg;
    logic [MISS_W-1:0] miss_threshold_reg;
    logic [CAP_W-1:0]  bucket_capacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_hash_high_reg <= '0;
            local_hash_low_reg  <= '0;
            local_ip_reg        <= '0;
            local_port_reg      <= '0;
            external_ip_reg     <= '0;
            miss_threshold_reg  <= MISS_W'(3);
            bucket_capacity_reg <= CAP_W'(8);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LOCAL_HASH_HIGH: local_hash_high_reg <= cfg_wdata;
                CFG_LOCAL_HASH_LOW:  local_hash_low_reg  <= cfg_wdata;
                CFG_LOCAL_IP:        local_ip_reg        <= cfg_wdata[IP_W-1:0];
                CFG_LOCAL_PORT:      local_port_reg      <= cfg_wdata[PORT_W-1:0];
                CFG_EXTERNAL_IP:     external_ip_reg     <= cfg_wdata[IP_W-1:0];
                CFG_MISS_THRESHOLD:  miss_threshold_reg  <= cfg_wdata[MISS_W-1:0];
                CFG_BUCKET_CAPACITY: bucket_capacity_reg <= cfg_wdata[CAP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input item
    logic [HASH_W-1:0] ph_reg;
    logic [HASH_W-1:0] pl_reg;
    logic [IP_W-1:0]   ip_reg;
    logic [PORT_W-1:0] port_reg;
    logic              alive_reg;
    logic              nonr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            ph_reg    <= s_tdata[HASH_W-1:0];
            pl_reg    <= s_tdata[2*HASH_W-1:HASH_W];
            ip_reg    <= s_tdata[2*HASH_W+IP_W-1:2*HASH_W];
            port_reg  <= s_tdata[IN_DATA_W-1:2*HASH_W+IP_W];
            alive_reg <= s_tuser[0];
            nonr_reg  <= s_tuser[1];
        end
    end

    logic [2*HASH_W-1:0] x_all;
    logic [CHUNK_W-1:0]  chunk_word;
    logic                ignore;

    assign x_all = {ph_reg ^ local_hash_high_reg, pl_reg ^ local_hash_low_reg};
    assign ignore = (x_all == '0) || ((ip_reg == local_ip_reg) && (port_reg == local_port_reg))
                    || nonr_reg || (ip_reg == external_ip_reg) || (ip_reg == local_ip_reg);

    // bucket search, one 16-bit chunk a cycle from the top
    logic [CHUNK_IDX_W-1:0] chunk_reg;
    logic [BKT_W-1:0]       bucket_reg;

    assign chunk_word = x_all[chunk_reg*CHUNK_W +: CHUNK_W];

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            chunk_reg <= CHUNK_IDX_W'(NUM_CHUNKS - 1);
        end
        else if (cmd.find_step)
        begin
            if (chunk_word != '0)
            begin
                bucket_reg <= {chunk_reg, top16(chunk_word)};
            end
            else
            begin
                chunk_reg <= chunk_reg - 1'b1;
            end
        end
    end

    // per-bucket metadata: valid mask, age ranks, count
    logic [MW-1:0]          meta_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] row_vld_reg;
    logic [MW-1:0]          meta_rd_reg;
    logic                   meta_hit_reg;
    logic [MW-1:0]          meta_q;
    logic [MW-1:0]          meta_next;
    logic [BUCKET_SIZE-1:0] vld_q;
    logic [RW-1:0]          rank_q [BUCKET_SIZE];
    logic [CW-1:0]          cnt_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg  <= '0;
            meta_hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                row_vld_reg[bucket_reg] <= 1'b1;
            end
            if (cmd.meta_rd)
            begin
                meta_hit_reg <= row_vld_reg[bucket_reg];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.meta_rd)
        begin
            meta_rd_reg <= meta_mem[bucket_reg];
        end
        if (cmd.update)
        begin
            meta_mem[bucket_reg] <= meta_next;
        end
    end

    assign meta_q = meta_hit_reg ? meta_rd_reg : '0;
    assign vld_q  = meta_q[BUCKET_SIZE-1:0];
    assign cnt_q  = meta_q[MW-1 -: CW];

    always_comb
    begin
        for (int i = 0; i < BUCKET_SIZE; i++)
        begin
            rank_q[i] = meta_q[BUCKET_SIZE + i*RW +: RW];
        end
    end

    // entry store
    logic [EW-1:0]     ent_mem [SLOTS];
    logic [EW-1:0]     ent_rd_reg;
    logic [AW-1:0]     base;
    logic [AW-1:0]     rd_addr;
    logic [CW-1:0]     sc_reg;
    logic [IW-1:0]     prev_idx;
    logic              ent_we;
    logic [IW-1:0]     ent_widx;
    logic [EW-1:0]     ent_wdata;

    assign base    = AW'(bucket_reg) * AW'(BUCKET_SIZE);
    assign rd_addr = base + AW'(sc_reg[IW-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            ent_rd_reg <= ent_mem[rd_addr];
        end
        if (cmd.update && ent_we)
        begin
            ent_mem[base + AW'(ent_widx)] <= ent_wdata;
        end
    end

    // scan: match by hash and oldest by rank
    logic              found_reg;
    logic [IW-1:0]     fidx_reg;
    logic [EW-1:0]     fent_reg;
    logic              old_ok_reg;
    logic [IW-1:0]     old_idx_reg;
    logic [RW-1:0]     old_rank_reg;

    assign prev_idx = IW'(sc_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            sc_reg     <= '0;
            found_reg  <= 1'b0;
            old_ok_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            sc_reg <= sc_reg + 1'b1;
            if (sc_reg != '0 && vld_q[prev_idx])
            begin
                if (!found_reg && ent_rd_reg[HASH_W-1:0] == ph_reg
                    && ent_rd_reg[2*HASH_W-1:HASH_W] == pl_reg)
                begin
                    found_reg <= 1'b1;
                    fidx_reg  <= prev_idx;
                    fent_reg  <= ent_rd_reg;
                end
                if (!old_ok_reg || rank_q[prev_idx] < old_rank_reg)
                begin
                    old_ok_reg   <= 1'b1;
                    old_idx_reg  <= prev_idx;
                    old_rank_reg <= rank_q[prev_idx];
                end
            end
        end
    end

    // update decision
    logic              free_ok;
    logic [IW-1:0]     free_idx;
    logic [KW-1:0]     cap;
    logic [MISS_W-1:0] old_m;
    logic [MISS_W-1:0] new_m;
    logic              drop_en;
    logic [IW-1:0]     drop_idx;
    logic [RW-1:0]     drop_rank;
    logic              ins_en;
    logic [IW-1:0]     ins_idx;
    status_t           upd_status;
    logic [BUCKET_SIZE-1:0] vld1;
    logic [RW-1:0]     rank1 [BUCKET_SIZE];
    logic [CW-1:0]     cnt1;
    logic [BUCKET_SIZE-1:0] vld2;
    logic [RW-1:0]     rank2 [BUCKET_SIZE];
    logic [CW-1:0]     cnt2;
    logic [BUCKET_SIZE*RW-1:0] rank_flat;

    always_comb
    begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = BUCKET_SIZE - 1; i >= 0; i--)
        begin
            if (!vld_q[i])
            begin
                free_ok  = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    always_comb
    begin
        if (bucket_capacity_reg == '0)
        begin
            cap = KW'(1);
        end
        else if (KW'(bucket_capacity_reg) > KW'(BUCKET_SIZE))
        begin
            cap = KW'(BUCKET_SIZE);
        end
        else
        begin
            cap = KW'(bucket_capacity_reg);
        end
    end

    assign old_m = fent_reg[EW-1 -: MISS_W];

    always_comb
    begin
        new_m      = '0;
        drop_en    = 1'b0;
        drop_idx   = '0;
        ins_en     = 1'b0;
        ins_idx    = free_idx;
        ent_we     = 1'b0;
        ent_widx   = fidx_reg;
        ent_wdata  = fent_reg;
        upd_status = ST_ABSENT;
        if (found_reg)
        begin
            if (alive_reg)
            begin
                new_m      = '0;
                upd_status = ST_REFRESHED;
            end
            else
            begin
                new_m      = (old_m == '1) ? old_m : old_m + 1'b1;
                upd_status = ST_MISS;
            end
            ent_we    = 1'b1;
            ent_wdata = {new_m, fent_reg[EW-MISS_W-1:0]};
            if (new_m >= miss_threshold_reg)
            begin
                drop_en    = 1'b1;
                drop_idx   = fidx_reg;
                upd_status = ST_REMOVED;
            end
        end
        else if (alive_reg)
        begin
            upd_status = ST_INSERTED;
            if ((KW'(cnt_q) >= cap || !free_ok) && old_ok_reg)
            begin
                drop_en    = 1'b1;
                drop_idx   = old_idx_reg;
                upd_status = ST_EVICTED;
                if (!free_ok)
                begin
                    ins_idx = old_idx_reg;
                end
            end
            ins_en    = free_ok || old_ok_reg;
            ent_we    = ins_en;
            ent_widx  = ins_idx;
            ent_wdata = {MISS_W'(0), port_reg, ip_reg, pl_reg, ph_reg};
        end
    end

    assign drop_rank = rank_q[drop_idx];

    always_comb
    begin
        for (int i = 0; i < BUCKET_SIZE; i++)
        begin
            vld1[i]  = vld_q[i];
            rank1[i] = rank_q[i];
            if (drop_en)
            begin
                if (IW'(i) == drop_idx)
                begin
                    vld1[i] = 1'b0;
                end
                if (vld_q[i] && IW'(i) != drop_idx && rank_q[i] > drop_rank)
                begin
                    rank1[i] = rank_q[i] - 1'b1;
                end
            end
        end
        cnt1 = (drop_en && cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
        for (int i = 0; i < BUCKET_SIZE; i++)
        begin
            vld2[i]  = vld1[i];
            rank2[i] = rank1[i];
            if (ins_en && IW'(i) == ins_idx)
            begin
                vld2[i]  = 1'b1;
                rank2[i] = RW'(cnt1);
            end
            rank_flat[i*RW +: RW] = rank2[i];
        end
        cnt2 = ins_en ? cnt1 + 1'b1 : cnt1;
    end

    assign meta_next = {cnt2, rank_flat, vld2};

    // result and output registers
    status_t           res_status_reg;
    logic [BKT_W-1:0]  res_bucket_reg;
    logic [FILL_W-1:0] res_fill_reg;
    logic              m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.check && ignore)
        begin
            res_status_reg <= ST_IGNORED;
            res_bucket_reg <= '0;
            res_fill_reg   <= '0;
        end
        else if (cmd.update)
        begin
            res_status_reg <= upd_status;
            res_bucket_reg <= bucket_reg;
            res_fill_reg   <= FILL_W'(cnt2);
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= OUT_DATA_W'({res_fill_reg, res_bucket_reg, res_status_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign sts.ignore    = ignore;
    assign sts.chunk_hit = (chunk_word != '0);
    assign sts.scan_last = (sc_reg == CW'(BUCKET_SIZE));
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    `KBPS_ASSERT_IMP(a_meta_count, clk, rst_n, cmd.scan_step, $countones(vld_q) == cnt_q)
    `KBPS_ASSERT_IMP(a_insert_free, clk, rst_n, cmd.update && ins_en, !vld1[ins_idx])
    `KBPS_ASSERT_NEXT(a_out_valid, clk, rst_n, cmd.out_load, m_tvalid_reg)

endmodule
